@@ rtl/core/snpt_pkg.sv @@
// ----------------------------------------------------------------------------
// snpt_pkg: shared types and constants for the per-sector noisy pixel ranking
// Field widths, counter limits, item modes and the structs passed from the
// top level to the sector rows.
// ----------------------------------------------------------------------------
package snpt_pkg;

  // sensor geometry and defaults
  localparam int COLUMNS       = 1024;
  localparam int SECTORS_DEF   = 4;
  localparam int TOP_DEPTH_DEF = 64;

  // beat field widths
  localparam int MODE_W    = 2;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 9;
  localparam int CNT_W     = 16;
  localparam int RSEC_W    = 2;
  localparam int RANK_W    = 6;
  localparam int SPIX_W    = 18;
  localparam int TPIX_W    = 20;
  localparam int LISTED_OW = 7;

  // wide enough for any list fill count and any slot index
  localparam int LISTED_W  = 9;
  // a column compare that still holds the upper sector edge
  localparam int COLX_W    = COL_W + 1;
  // sector index compare, covers the largest sector count
  localparam int SECX_W    = 5;

  // cells per group in the registered read tree
  localparam int GRP = 8;

  // saturation limits
  localparam logic [SPIX_W-1:0] SECTOR_CAP = SPIX_W'(131072);
  localparam logic [TPIX_W-1:0] TOTAL_CAP  = TPIX_W'(524288);

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // one top list slot
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } entry_t;

  // controls and payload broadcast to every sector row
  typedef struct packed {
    logic              rec;
    logic              clr;
    logic              rd;
    logic              noisy;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  hits;
    logic [RANK_W-1:0] rank;
  } row_ctl_t;

  // state of one sector captured by a read
  typedef struct packed {
    entry_t               entry;
    logic [SPIX_W-1:0]    spix;
    logic [SPIX_W-1:0]    snoisy;
    logic [LISTED_W-1:0]  listed;
  } rd_snap_t;

endpackage

@@ rtl/core/snpt_cell.sv @@
// ----------------------------------------------------------------------------
// snpt_cell: one slot of a sector's sorted top list
// Compares the incoming hit count with its own, then keeps its entry, takes
// the new record or takes the entry of the slot ahead of it.
// ----------------------------------------------------------------------------
module snpt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             ins,
  input  snpt_pkg::entry_t new_ent,
  input  snpt_pkg::entry_t prev_ent,
  input  logic             prev_ge,
  output snpt_pkg::entry_t cur_ent,
  output logic             ge
);
  import snpt_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  entry_t           src;
  logic             take;

  // new record belongs at or ahead of this slot
  assign ge   = new_ent.count >= count_r;
  assign take = ins & ge;
  // the slot ahead also moved, so shift its entry down
  assign src  = prev_ge ? prev_ent : new_ent;

  // slot count, zero marks empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clr) begin
      count_r <= '0;
    end else if (take) begin
      count_r <= src.count;
    end
  end

  // pixel address
  always_ff @(posedge clk) begin
    if (take) begin
      col_r <= src.col;
      row_r <= src.row;
    end
  end

  assign cur_ent.count = count_r;
  assign cur_ent.col   = col_r;
  assign cur_ent.row   = row_r;

endmodule

@@ rtl/core/snpt_row.sv @@
// ----------------------------------------------------------------------------
// snpt_row: one sector
// Chain of list cells, the sector's pixel, noisy and fill counters, and the
// read capture registers that group the cells for the rank select.
// ----------------------------------------------------------------------------
module snpt_row #(
  parameter int TOP_DEPTH = snpt_pkg::TOP_DEPTH_DEF,
  parameter int SECTORS   = snpt_pkg::SECTORS_DEF,
  parameter int SEC_IDX   = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  snpt_pkg::row_ctl_t ctl,
  output snpt_pkg::rd_snap_t snap
);
  import snpt_pkg::*;

  localparam int SECTOR_W = COLUMNS / SECTORS;
  localparam int LO       = SEC_IDX * SECTOR_W;
  localparam int HI       = (SEC_IDX + 1) * SECTOR_W;
  localparam int LIST_W   = $clog2(TOP_DEPTH + 1);
  localparam int NGRP     = (TOP_DEPTH + GRP - 1) / GRP;

  entry_t                 cur   [TOP_DEPTH];
  logic                   ge    [TOP_DEPTH];
  entry_t                 qpad  [NGRP*GRP];
  entry_t                 new_ent;
  logic [COLX_W-1:0]      col_x;
  logic                   match;
  logic                   ins;
  logic [LISTED_W-1:0]    rank_x;

  logic [SPIX_W-1:0]      spix_r;
  logic [SPIX_W-1:0]      snoisy_r;
  logic [LIST_W-1:0]      listed_r;

  entry_t                 grp_r   [NGRP];
  entry_t                 grp_nxt [NGRP];
  logic [SPIX_W-1:0]      spix_snap_r;
  logic [SPIX_W-1:0]      snoisy_snap_r;
  logic [LISTED_W-1:0]    listed_snap_r;
  entry_t                 rd_ent;

  // sector decode, the last sector takes any columns past the edge
  assign col_x = {1'b0, ctl.col};
  assign match = (col_x >= COLX_W'(LO)) &&
                 ((SEC_IDX == SECTORS - 1) || (col_x < COLX_W'(HI)));
  assign ins   = ctl.rec & ctl.noisy & match;

  assign new_ent.count = ctl.hits;
  assign new_ent.col   = ctl.col;
  assign new_ent.row   = ctl.row;

  // list cells, each fed by its neighbor ahead
  for (genvar j = 0; j < TOP_DEPTH; j++) begin : g_cell
    if (j == 0) begin : g_head
      snpt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (ctl.clr),
        .ins      (ins),
        .new_ent  (new_ent),
        .prev_ent (new_ent),
        .prev_ge  (1'b0),
        .cur_ent  (cur[j]),
        .ge       (ge[j])
      );
    end else begin : g_body
      snpt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (ctl.clr),
        .ins      (ins),
        .new_ent  (new_ent),
        .prev_ent (cur[j-1]),
        .prev_ge  (ge[j-1]),
        .cur_ent  (cur[j]),
        .ge       (ge[j])
      );
    end
  end

  // sector counters, saturating
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      spix_r   <= '0;
      snoisy_r <= '0;
      listed_r <= '0;
    end else begin
      if (ctl.rec && match && (spix_r < SECTOR_CAP)) begin
        spix_r <= spix_r + 1'b1;
      end
      if (ins && (snoisy_r < SECTOR_CAP)) begin
        snoisy_r <= snoisy_r + 1'b1;
      end
      // the fill count grows only while the last slot is still free
      if (ins && (cur[TOP_DEPTH-1].count == '0)) begin
        listed_r <= listed_r + 1'b1;
      end
    end
  end

  // pad the cell row out to whole groups
  for (genvar j = 0; j < NGRP*GRP; j++) begin : g_pad
    if (j < TOP_DEPTH) begin : g_live
      assign qpad[j] = cur[j];
    end else begin : g_zero
      assign qpad[j] = '0;
    end
  end

  // rank select, first level: one-hot and-or inside each group
  assign rank_x = LISTED_W'(ctl.rank);
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (rank_x == LISTED_W'(g*GRP + k)) begin
          grp_nxt[g] = grp_nxt[g] | qpad[g*GRP + k];
        end
      end
    end
  end

  // capture on a read beat
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      grp_r         <= grp_nxt;
      spix_snap_r   <= spix_r;
      snoisy_snap_r <= snoisy_r;
      listed_snap_r <= LISTED_W'(listed_r);
    end
  end

  // rank select, second level across the groups
  always_comb begin
    rd_ent = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_ent = rd_ent | grp_r[g];
    end
  end

  assign snap.entry  = rd_ent;
  assign snap.spix   = spix_snap_r;
  assign snap.snoisy = snoisy_snap_r;
  assign snap.listed = listed_snap_r;

endmodule

@@ rtl/core/sector_noisy_pixel_top_k.sv @@
// ----------------------------------------------------------------------------
// sector_noisy_pixel_top_k: per-sector noisy pixel counters and top lists
// Counts pixel records per sector and overall and keeps a descending list of
// the noisiest pixels of each sector; a read beat returns one list entry.
// ----------------------------------------------------------------------------
// Pixel records, clears and ignored beats can arrive back to back while no
// read waits in the capture stage: every sector is a chain of list cells that
// inserts a record in the cycle it is accepted, shifting lower entries one slot
// down. A read beat captures the addressed rank of every sector (first half of
// a two-level select) and its counters at the accept edge; the second level
// feeds the result register, and the input takes nothing in the cycle right
// after a read. While a result waits on out_ready the input keeps running until
// a second read is waiting in the capture stage. Reset clears the counts,
// counters and valid flags at once, with no clearing pass.
module sector_noisy_pixel_top_k #(
  parameter int SECTORS   = snpt_pkg::SECTORS_DEF,
  parameter int TOP_DEPTH = snpt_pkg::TOP_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [snpt_pkg::CNT_W-1:0]      cfg_wr_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [snpt_pkg::MODE_W-1:0]     in_mode,
  input  logic [snpt_pkg::COL_W-1:0]      in_pixel_col,
  input  logic [snpt_pkg::ROW_W-1:0]      in_pixel_row,
  input  logic [snpt_pkg::CNT_W-1:0]      in_hit_count,
  input  logic [snpt_pkg::RSEC_W-1:0]     in_read_sector,
  input  logic [snpt_pkg::RANK_W-1:0]     in_read_rank,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [snpt_pkg::COL_W-1:0]      out_entry_col,
  output logic [snpt_pkg::ROW_W-1:0]      out_entry_row,
  output logic [snpt_pkg::CNT_W-1:0]      out_entry_count,
  output logic [snpt_pkg::SPIX_W-1:0]     out_sector_pixels,
  output logic [snpt_pkg::SPIX_W-1:0]     out_sector_noisy,
  output logic [snpt_pkg::LISTED_OW-1:0]  out_sector_listed,
  output logic [snpt_pkg::TPIX_W-1:0]     out_total_pixels,
  output logic [snpt_pkg::TPIX_W-1:0]     out_total_noisy
);
  import snpt_pkg::*;

  logic [CNT_W-1:0]      thr_r;
  logic                  acc;
  mode_t                 mode;
  row_ctl_t              ctl;
  rd_snap_t              snap [SECTORS];

  logic [TPIX_W-1:0]     tpix_r;
  logic [TPIX_W-1:0]     tnoisy_r;

  logic                  s1_v_r;
  logic [RSEC_W-1:0]     s1_sec_r;
  logic [TPIX_W-1:0]     s1_tpix_r;
  logic [TPIX_W-1:0]     s1_tnoisy_r;
  logic                  adv;

  rd_snap_t              sel;
  logic [LISTED_W-1:0]   listed_w;

  logic                  out_valid_r;
  logic [COL_W-1:0]      out_col_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [SPIX_W-1:0]     out_spix_r;
  logic [SPIX_W-1:0]     out_snoisy_r;
  logic [LISTED_OW-1:0]  out_listed_r;
  logic [TPIX_W-1:0]     out_tpix_r;
  logic [TPIX_W-1:0]     out_tnoisy_r;

  // noise threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // input beat decode
  assign in_ready  = !s1_v_r;
  assign acc       = in_valid & in_ready;
  assign mode      = mode_t'(in_mode);
  assign ctl.rec   = acc && (mode == MODE_PIXEL);
  assign ctl.rd    = acc && (mode == MODE_READ);
  assign ctl.clr   = acc && (mode == MODE_CLEAR);
  assign ctl.noisy = in_hit_count > thr_r;
  assign ctl.col   = in_pixel_col;
  assign ctl.row   = in_pixel_row;
  assign ctl.hits  = in_hit_count;
  assign ctl.rank  = in_read_rank;

  // sector rows
  for (genvar s = 0; s < SECTORS; s++) begin : g_row
    snpt_row #(
      .TOP_DEPTH (TOP_DEPTH),
      .SECTORS   (SECTORS),
      .SEC_IDX   (s)
    ) u_row (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .snap  (snap[s])
    );
  end

  // global counters, saturating
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      tpix_r   <= '0;
      tnoisy_r <= '0;
    end else if (ctl.rec) begin
      if (tpix_r < TOTAL_CAP) begin
        tpix_r <= tpix_r + 1'b1;
      end
      if (ctl.noisy && (tnoisy_r < TOTAL_CAP)) begin
        tnoisy_r <= tnoisy_r + 1'b1;
      end
    end
  end

  // read capture stage
  assign adv = s1_v_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ctl.rd) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      s1_sec_r    <= in_read_sector;
      s1_tpix_r   <= tpix_r;
      s1_tnoisy_r <= tnoisy_r;
    end
  end

  // sector select, nothing matches a sector past the last one
  always_comb begin
    sel = '0;
    for (int s = 0; s < SECTORS; s++) begin
      if (SECX_W'(s1_sec_r) == SECX_W'(s)) begin
        sel = snap[s];
      end
    end
  end

  assign listed_w = sel.listed;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // an empty slot reports a zero address
      if (sel.entry.count == '0) begin
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        out_col_r <= sel.entry.col;
        out_row_r <= sel.entry.row;
      end
      out_count_r  <= sel.entry.count;
      out_spix_r   <= sel.spix;
      out_snoisy_r <= sel.snoisy;
      out_listed_r <= listed_w[LISTED_OW-1:0];
      out_tpix_r   <= s1_tpix_r;
      out_tnoisy_r <= s1_tnoisy_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_col     = out_col_r;
  assign out_entry_row     = out_row_r;
  assign out_entry_count   = out_count_r;
  assign out_sector_pixels = out_spix_r;
  assign out_sector_noisy  = out_snoisy_r;
  assign out_sector_listed = out_listed_r;
  assign out_total_pixels  = out_tpix_r;
  assign out_total_noisy   = out_tnoisy_r;

  // a read beat always lands in the capture stage
  assert property (@(posedge clk) disable iff (!rst_n) ctl.rd |=> s1_v_r)
    else $error("read beat not captured");

  // an empty slot never reports an address
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r == '0)) |-> ((out_col_r == '0) && (out_row_r == '0)))
    else $error("empty slot with nonzero address");

  // noisy counts never pass pixel counts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_snoisy_r <= out_spix_r) && (out_tnoisy_r <= out_tpix_r)))
    else $error("noisy count above pixel count");

  // the global counters never pass their limit
  assert property (@(posedge clk) disable iff (!rst_n)
    (tpix_r <= TOTAL_CAP) && (tnoisy_r <= tpix_r))
    else $error("global counter out of range");

endmodule

@@ test/sector_noisy_pixel_top_k_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_noisy_pixel_top_k_tb: self-checking bench for the noisy pixel ranking
// Streams pixel records, reads, clears and ignored beats through the block,
// predicts every read result from a behavioral copy of the sector lists and
// counters, and checks each result beat field by field in order.
// ----------------------------------------------------------------------------
module sector_noisy_pixel_top_k_tb;
  import snpt_pkg::*;

  localparam int SECTORS       = SECTORS_DEF;
  localparam int TOP_DEPTH     = TOP_DEPTH_DEF;
  localparam int SECTOR_WIDTH  = COLUMNS / SECTORS;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BEATS   = 450;
  localparam int BURST_BEATS   = 100;
  localparam int LIMIT_CYCLES  = 1000000;

  // one input beat
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CNT_W-1:0]  hits;
    logic [RSEC_W-1:0] rsec;
    logic [RANK_W-1:0] rank;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic [CNT_W-1:0]     count;
    logic [SPIX_W-1:0]    spix;
    logic [SPIX_W-1:0]    snoisy;
    logic [LISTED_OW-1:0] listed;
    logic [TPIX_W-1:0]    tpix;
    logic [TPIX_W-1:0]    tnoisy;
  } res_t;

  // behavioral sector lists and counters, plus the queue of predicted reads
  class pixel_rank_board;
    logic [CNT_W-1:0]  threshold;
    entry_t            slots [SECTORS][TOP_DEPTH];
    logic [SPIX_W-1:0] sec_pix [SECTORS];
    logic [SPIX_W-1:0] sec_noisy [SECTORS];
    logic [TPIX_W-1:0] all_pix;
    logic [TPIX_W-1:0] all_noisy;
    res_t              pending [$];
    int                errors;

    function new();
      threshold = '0;
      errors    = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (slots[s, j]) slots[s][j] = '0;
      foreach (sec_pix[s]) begin
        sec_pix[s]   = '0;
        sec_noisy[s] = '0;
      end
      all_pix   = '0;
      all_noisy = '0;
    endfunction

    function void set_threshold(logic [CNT_W-1:0] v);
      threshold = v;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // descending insert, newer entry ahead of equal ones, tail drops off
    function void insert_entry(int s, beat_t b);
      bit placed;
      placed = 1'b0;
      for (int j = 0; j < TOP_DEPTH; j++) begin
        if (!placed && b.hits >= slots[s][j].count) begin
          for (int k = TOP_DEPTH - 1; k > j; k--) slots[s][k] = slots[s][k-1];
          slots[s][j].count = b.hits;
          slots[s][j].col   = b.col;
          slots[s][j].row   = b.row;
          placed = 1'b1;
        end
      end
    endfunction

    // update the state for an accepted beat, queue the result of a read
    function void note_input(beat_t b);
      int   s;
      int   filled;
      res_t r;
      case (b.mode)
        MODE_PIXEL: begin
          s = int'(b.col) / SECTOR_WIDTH;
          if (s >= SECTORS) s = SECTORS - 1;
          if (sec_pix[s] < SECTOR_CAP) sec_pix[s] = sec_pix[s] + 1'b1;
          if (all_pix < TOTAL_CAP) all_pix = all_pix + 1'b1;
          if (b.hits > threshold) begin
            if (sec_noisy[s] < SECTOR_CAP) sec_noisy[s] = sec_noisy[s] + 1'b1;
            if (all_noisy < TOTAL_CAP) all_noisy = all_noisy + 1'b1;
            insert_entry(s, b);
          end
        end
        MODE_READ: begin
          r = '0;
          s = int'(b.rsec);
          if (s < SECTORS) begin
            if (int'(b.rank) < TOP_DEPTH && slots[s][b.rank].count != '0) begin
              r.col   = slots[s][b.rank].col;
              r.row   = slots[s][b.rank].row;
              r.count = slots[s][b.rank].count;
            end
            filled = 0;
            for (int j = 0; j < TOP_DEPTH; j++)
              if (slots[s][j].count != '0) filled++;
            r.spix   = sec_pix[s];
            r.snoisy = sec_noisy[s];
            r.listed = LISTED_OW'(filled);
          end
          r.tpix   = all_pix;
          r.tnoisy = all_noisy;
          pending.push_back(r);
        end
        MODE_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // compare a result beat against the oldest predicted read
    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual count %0d",
                 $time, got.count);
        return;
      end
      want = pending.pop_front();
      compare_field("entry_col", 32'(want.col), 32'(got.col));
      compare_field("entry_row", 32'(want.row), 32'(got.row));
      compare_field("entry_count", 32'(want.count), 32'(got.count));
      compare_field("sector_pixels", 32'(want.spix), 32'(got.spix));
      compare_field("sector_noisy", 32'(want.snoisy), 32'(got.snoisy));
      compare_field("sector_listed", 32'(want.listed), 32'(got.listed));
      compare_field("total_pixels", 32'(want.tpix), 32'(got.tpix));
      compare_field("total_noisy", 32'(want.tnoisy), 32'(got.tnoisy));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = MODE_PIXEL;
  logic [COL_W-1:0]     in_pixel_col = '0;
  logic [ROW_W-1:0]     in_pixel_row = '0;
  logic [CNT_W-1:0]     in_hit_count = '0;
  logic [RSEC_W-1:0]    in_read_sector = '0;
  logic [RANK_W-1:0]    in_read_rank = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COL_W-1:0]     out_entry_col;
  logic [ROW_W-1:0]     out_entry_row;
  logic [CNT_W-1:0]     out_entry_count;
  logic [SPIX_W-1:0]    out_sector_pixels;
  logic [SPIX_W-1:0]    out_sector_noisy;
  logic [LISTED_OW-1:0] out_sector_listed;
  logic [TPIX_W-1:0]    out_total_pixels;
  logic [TPIX_W-1:0]    out_total_noisy;

  pixel_rank_board board;
  int              in_idle_pct = 0;
  int              out_idle_pct = 0;
  int              cycle_count = 0;
  logic [CNT_W-1:0] cur_threshold = '0;

  sector_noisy_pixel_top_k #(
    .SECTORS   (SECTORS),
    .TOP_DEPTH (TOP_DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_pixel_col      (in_pixel_col),
    .in_pixel_row      (in_pixel_row),
    .in_hit_count      (in_hit_count),
    .in_read_sector    (in_read_sector),
    .in_read_rank      (in_read_rank),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_entry_col     (out_entry_col),
    .out_entry_row     (out_entry_row),
    .out_entry_count   (out_entry_count),
    .out_sector_pixels (out_sector_pixels),
    .out_sector_noisy  (out_sector_noisy),
    .out_sector_listed (out_sector_listed),
    .out_total_pixels  (out_total_pixels),
    .out_total_noisy   (out_total_noisy)
  );

  // clock
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin : result_monitor
    res_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.col    = out_entry_col;
      seen.row    = out_entry_row;
      seen.count  = out_entry_count;
      seen.spix   = out_sector_pixels;
      seen.snoisy = out_sector_noisy;
      seen.listed = out_sector_listed;
      seen.tpix   = out_total_pixels;
      seen.tnoisy = out_total_noisy;
      board.check_result(seen);
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  function automatic beat_t pixel_beat(int col, int row, int hits);
    beat_t b;
    b      = '0;
    b.mode = MODE_PIXEL;
    b.col  = COL_W'(col);
    b.row  = ROW_W'(row);
    b.hits = CNT_W'(hits);
    return b;
  endfunction

  function automatic beat_t read_beat(int s, int rank);
    beat_t b;
    b      = '0;
    b.mode = MODE_READ;
    b.rsec = RSEC_W'(s);
    b.rank = RANK_W'(rank);
    return b;
  endfunction

  // random beat, hit counts biased around the threshold and onto repeats
  function automatic beat_t random_beat(logic [CNT_W-1:0] thr);
    beat_t       b;
    int unsigned pick;
    int          h;
    b.col  = COL_W'($urandom);
    b.row  = ROW_W'($urandom);
    b.rsec = RSEC_W'($urandom);
    b.rank = ($urandom_range(1) == 0) ? RANK_W'($urandom_range(7)) : RANK_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 66)      b.mode = MODE_PIXEL;
    else if (pick < 92) b.mode = MODE_READ;
    else if (pick < 93) b.mode = MODE_CLEAR;
    else                b.mode = MODE_NONE;
    case ($urandom_range(3))
      0: begin
        h = int'(thr) + int'($urandom_range(6)) - 3;
        if (h < 0) h = 0;
        if (h > 65535) h = 65535;
        b.hits = CNT_W'(h);
      end
      1: b.hits = CNT_W'($urandom_range(15) << 12);
      2: b.hits = CNT_W'($urandom);
      default: b.hits = CNT_W'($urandom_range(255));
    endcase
    return b;
  endfunction

  // present one beat and hold it until accepted
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= b.mode;
    in_pixel_col   <= b.col;
    in_pixel_row   <= b.row;
    in_hit_count   <= b.hits;
    in_read_sector <= b.rsec;
    in_read_rank   <= b.rank;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(b);
  endtask

  // stop sending until every predicted read has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_threshold(input logic [CNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_threshold(v);
    cur_threshold = v;
  endtask

  task automatic random_phase(input int beats);
    for (int i = 0; i < beats; i++) begin
      // hold off mid phase until drained, then move the threshold
      if (i == beats / 2) begin
        settle();
        write_threshold(CNT_W'($urandom));
      end
      send_beat(random_beat(cur_threshold));
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, field extremes, sector edges, ties, ignored beat
    in_idle_pct  = 8;
    out_idle_pct = 48;
    write_threshold('0);
    send_beat(read_beat(0, 0));
    send_beat(pixel_beat(0, 0, 0));
    send_beat(pixel_beat(1023, 511, 65535));
    send_beat(pixel_beat(255, 17, 100));
    send_beat(pixel_beat(256, 300, 100));
    send_beat(pixel_beat(10, 2, 100));
    send_beat(pixel_beat(20, 3, 50));
    send_beat('{mode: MODE_NONE, col: '1, row: '1, hits: '1, rsec: '1, rank: '1});
    send_beat(read_beat(0, 0));
    send_beat(read_beat(0, 1));
    send_beat(read_beat(0, 2));
    send_beat(read_beat(0, 3));
    send_beat(read_beat(1, 63));
    send_beat(read_beat(3, 0));
    send_beat(read_beat(2, 0));
    settle();
    // top threshold, nothing can be noisy
    write_threshold('1);
    send_beat(pixel_beat(512, 0, 65535));
    send_beat(read_beat(2, 0));
    settle();
    // hit count equal to and just above the threshold
    write_threshold(CNT_W'(99));
    send_beat(pixel_beat(700, 44, 99));
    send_beat(pixel_beat(700, 45, 100));
    send_beat(read_beat(2, 0));
    send_beat('{mode: MODE_CLEAR, col: '0, row: '0, hits: '0, rsec: '0, rank: '0});
    send_beat(read_beat(3, 0));
    send_beat(read_beat(0, 0));
    settle();

    // random phases with changing idle patterns
    write_threshold(CNT_W'($urandom_range(3000)));
    random_phase(PHASE_BEATS);
    settle();
    in_idle_pct  = 48;
    out_idle_pct = 8;
    write_threshold(CNT_W'($urandom_range(65535)));
    random_phase(PHASE_BEATS);
    settle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_threshold(CNT_W'($urandom_range(500)));
    random_phase(PHASE_BEATS);
    settle();

    // burst into one sector to fill its list and push entries off the tail
    write_threshold('0);
    for (int i = 0; i < BURST_BEATS; i++)
      send_beat(pixel_beat($urandom_range(SECTOR_WIDTH - 1), $urandom_range(511),
                           $urandom_range(65535, 1)));
    send_beat(read_beat(0, 0));
    send_beat(read_beat(0, TOP_DEPTH - 1));
    send_beat(read_beat(1, 0));
    send_beat('{mode: MODE_CLEAR, col: '0, row: '0, hits: '0, rsec: '0, rank: '0});
    send_beat(read_beat(0, 0));
    settle();

    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
